[hw/rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Types, token codes and character helpers for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned LineBits = 16;
  localparam int unsigned KindW    = 5;

  typedef logic [KindW-1:0] kind_t;

  localparam kind_t KNumber  = kind_t'(0);
  localparam kind_t KString  = kind_t'(1);
  localparam kind_t KIdent   = kind_t'(2);
  localparam kind_t KPrint   = kind_t'(3);
  localparam kind_t KIf      = kind_t'(4);
  localparam kind_t KNewline = kind_t'(5);
  localparam kind_t KPlus    = kind_t'(6);
  localparam kind_t KMinus   = kind_t'(7);
  localparam kind_t KStar    = kind_t'(8);
  localparam kind_t KSlash   = kind_t'(9);
  localparam kind_t KLParen  = kind_t'(10);
  localparam kind_t KRParen  = kind_t'(11);
  localparam kind_t KLBrace  = kind_t'(12);
  localparam kind_t KRBrace  = kind_t'(13);
  localparam kind_t KAssign  = kind_t'(14);
  localparam kind_t KEq      = kind_t'(15);
  localparam kind_t KGt      = kind_t'(16);
  localparam kind_t KGe      = kind_t'(17);
  localparam kind_t KLt      = kind_t'(18);
  localparam kind_t KLe      = kind_t'(19);
  localparam kind_t KNe      = kind_t'(20);
  localparam kind_t KUnknown = kind_t'(21);
  localparam kind_t KEof     = kind_t'(22);

  typedef enum logic [7:0] {
    ModeIdle    = 8'b0000_0001,
    ModeInt     = 8'b0000_0010,
    ModeFrac    = 8'b0000_0100,
    ModeStr     = 8'b0000_1000,
    ModeEsc     = 8'b0001_0000,
    ModeIdent   = 8'b0010_0000,
    ModeComment = 8'b0100_0000,
    ModeOp      = 8'b1000_0000
  } mode_e;

  typedef enum logic [1:0] {
    OpAssign = 2'd0,
    OpGt     = 2'd1,
    OpLt     = 2'd2,
    OpBang   = 2'd3
  } op_e;

  // keyword tracker: prefixes of "print" and "if"
  typedef enum logic [2:0] {
    KwNone = 3'd0,
    KwP    = 3'd1,
    KwPr   = 3'd2,
    KwPri  = 3'd3,
    KwPrin = 3'd4,
    KwPrint = 3'd5,
    KwI    = 3'd6,
    KwIf   = 3'd7
  } kw_e;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           text;
    logic                 has;
    logic                 last;
    logic [LineBits-1:0]  line;
  } result_t;

  function automatic result_t make_res(kind_t kind, logic [7:0] text, logic has,
                                       logic last, logic [LineBits-1:0] line);
    result_t r;
    r.kind = kind;
    r.text = has ? text : 8'd0;
    r.has  = has;
    r.last = last;
    r.line = line;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic kw_e kw_next(kw_e t, logic [7:0] c);
    kw_e n;
    n = KwNone;
    unique case (t)
      KwP:     if (c == "r") n = KwPr;
      KwPr:    if (c == "i") n = KwPri;
      KwPri:   if (c == "n") n = KwPrin;
      KwPrin:  if (c == "t") n = KwPrint;
      KwI:     if (c == "f") n = KwIf;
      default: n = KwNone;
    endcase
    return n;
  endfunction

  function automatic kind_t op_one(op_e p);
    kind_t k;
    unique case (p)
      OpAssign: k = KAssign;
      OpGt:     k = KGt;
      OpLt:     k = KLt;
      default:  k = KUnknown;
    endcase
    return k;
  endfunction

  function automatic kind_t op_two(op_e p);
    kind_t k;
    unique case (p)
      OpAssign: k = KEq;
      OpGt:     k = KGe;
      OpLt:     k = KLe;
      default:  k = KNe;
    endcase
    return k;
  endfunction

endpackage

[hw/rtl/source_text_tokenizer.sv]
// Source text tokenizer. Takes one source byte per beat (tuser = 1 marks end of
// source) and emits tokens one result per beat: number, string and identifier
// text streams byte by byte, then a closing beat with tlast carries the final
// kind. An input beat is accepted every cycle while the 4-entry result queue
// has two free slots; a byte that both closes a token and starts or ends
// another yields two result beats, so the sustained input rate is one byte per
// cycle for text that gives at most one result per byte and a receiver that
// never stalls, and drops where every byte gives two. Results pass through the
// result queue registers. An end of source flushes the pending token, emits
// end of file and returns the scanner to its reset state.
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-stream lexer with keyword, two-character operator and line tracking.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] source_byte
  input  logic        s_axis_tuser_i,   // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] text_byte, [23:8] line_number
  output logic [5:0]  m_axis_tuser_o,   // [4:0] token_kind, [5] has_byte
  output logic        m_axis_tlast_o    // token_end
);
  import stt_pkg::*;

  localparam logic [LineBits-1:0] LineMax = '1;

  mode_e               mode_q, mode_d;
  op_e                 pend_q, pend_d;
  kw_e                 kw_q, kw_d;
  logic [LineBits-1:0] line_q, line_d;

  result_t    fifo_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;

  logic       in_acc, out_acc;
  logic [7:0] c;
  logic       pre_v, idle_v, run_idle;
  result_t    pre, idle;

  assign c               = s_axis_tdata_i;
  assign s_axis_tready_o = (cnt_q <= 3'd2);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    kw_d     = kw_q;
    line_d   = line_q;
    pre_v    = 1'b0;
    pre      = make_res(KNumber, 8'd0, 1'b0, 1'b0, line_q);
    idle_v   = 1'b0;
    idle     = make_res(KNumber, 8'd0, 1'b0, 1'b0, line_q);
    run_idle = 1'b0;

    if (s_axis_tuser_i) begin
      unique case (mode_q)
        ModeInt, ModeFrac: begin
          pre_v = 1'b1;
          pre   = make_res(KNumber, 8'd0, 1'b0, 1'b1, line_q);
        end
        ModeStr, ModeEsc: begin
          pre_v = 1'b1;
          pre   = make_res(KString, 8'd0, 1'b0, 1'b1, line_q);
        end
        ModeIdent: begin
          pre_v = 1'b1;
          pre   = make_res((kw_q == KwPrint) ? KPrint : (kw_q == KwIf) ? KIf : KIdent,
                           8'd0, 1'b0, 1'b1, line_q);
        end
        ModeOp: begin
          pre_v = 1'b1;
          pre   = make_res(op_one(pend_q), "!", pend_q == OpBang, 1'b1, line_q);
        end
        default: ;
      endcase
      idle_v = 1'b1;
      idle   = make_res(KEof, 8'd0, 1'b0, 1'b1, line_q);
      mode_d = ModeIdle;
      pend_d = OpAssign;
      kw_d   = KwNone;
      line_d = LineBits'(1);
    end else begin
      unique case (mode_q)
        ModeInt, ModeFrac: begin
          if (is_digit(c) || (c == "." && mode_q == ModeInt)) begin
            pre_v = 1'b1;
            pre   = make_res(KNumber, c, 1'b1, 1'b0, line_q);
            if (c == ".") mode_d = ModeFrac;
          end else begin
            pre_v    = 1'b1;
            pre      = make_res(KNumber, 8'd0, 1'b0, 1'b1, line_q);
            run_idle = 1'b1;
          end
        end
        ModeStr: begin
          if (c == "\"") begin
            pre_v  = 1'b1;
            pre    = make_res(KString, 8'd0, 1'b0, 1'b1, line_q);
            mode_d = ModeIdle;
          end else if (c == "\\") begin
            mode_d = ModeEsc;
          end else begin
            pre_v = 1'b1;
            pre   = make_res(KString, c, 1'b1, 1'b0, line_q);
          end
        end
        ModeEsc: begin
          pre_v  = 1'b1;
          pre    = make_res(KString, (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : c,
                            1'b1, 1'b0, line_q);
          mode_d = ModeStr;
        end
        ModeIdent: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            kw_d  = kw_next(kw_q, c);
            pre_v = 1'b1;
            pre   = make_res(KIdent, c, 1'b1, 1'b0, line_q);
          end else begin
            pre_v    = 1'b1;
            pre      = make_res((kw_q == KwPrint) ? KPrint : (kw_q == KwIf) ? KIf : KIdent,
                                8'd0, 1'b0, 1'b1, line_q);
            kw_d     = KwNone;
            run_idle = 1'b1;
          end
        end
        ModeComment: begin
          if (c == "\n") run_idle = 1'b1;
        end
        ModeOp: begin
          pre_v  = 1'b1;
          pend_d = OpAssign;
          if (c == "=") begin
            pre    = make_res(op_two(pend_q), 8'd0, 1'b0, 1'b1, line_q);
            mode_d = ModeIdle;
          end else begin
            pre      = make_res(op_one(pend_q), "!", pend_q == OpBang, 1'b1, line_q);
            run_idle = 1'b1;
          end
        end
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        mode_d = ModeIdle;
        priority if (c == " " || c == "\t" || c == "\r") begin
        end else if (c == "\n") begin
          idle_v = 1'b1;
          idle   = make_res(KNewline, 8'd0, 1'b0, 1'b1, line_q);
          if (line_q != LineMax) line_d = line_q + LineBits'(1);
        end else if (c == "#") begin
          mode_d = ModeComment;
        end else if (is_digit(c)) begin
          mode_d = ModeInt;
          idle_v = 1'b1;
          idle   = make_res(KNumber, c, 1'b1, 1'b0, line_q);
        end else if (c == "\"") begin
          mode_d = ModeStr;
        end else if (is_alpha(c) || c == "_") begin
          mode_d = ModeIdent;
          kw_d   = (c == "p") ? KwP : (c == "i") ? KwI : KwNone;
          idle_v = 1'b1;
          idle   = make_res(KIdent, c, 1'b1, 1'b0, line_q);
        end else if (c == "+") begin
          idle_v = 1'b1;
          idle   = make_res(KPlus, 8'd0, 1'b0, 1'b1, line_q);
        end else if (c == "-") begin
          idle_v = 1'b1;
          idle   = make_res(KMinus, 8'd0, 1'b0, 1'b1, line_q);
        end else if (c == "*") begin
          idle_v = 1'b1;
          idle   = make_res(KStar, 8'd0, 1'b0, 1'b1, line_q);
        end else if (c == "/") begin
          idle_v = 1'b1;
          idle   = make_res(KSlash, 8'd0, 1'b0, 1'b1, line_q);
        end else if (c == "(") begin
          idle_v = 1'b1;
          idle   = make_res(KLParen, 8'd0, 1'b0, 1'b1, line_q);
        end else if (c == ")") begin
          idle_v = 1'b1;
          idle   = make_res(KRParen, 8'd0, 1'b0, 1'b1, line_q);
        end else if (c == "{") begin
          idle_v = 1'b1;
          idle   = make_res(KLBrace, 8'd0, 1'b0, 1'b1, line_q);
        end else if (c == "}") begin
          idle_v = 1'b1;
          idle   = make_res(KRBrace, 8'd0, 1'b0, 1'b1, line_q);
        end else if (c == "=" || c == ">" || c == "<" || c == "!") begin
          mode_d = ModeOp;
          pend_d = (c == "=") ? OpAssign : (c == ">") ? OpGt : (c == "<") ? OpLt : OpBang;
        end else begin
          idle_v = 1'b1;
          idle   = make_res(KUnknown, c, 1'b1, 1'b1, line_q);
        end
      end
    end
  end

  logic [1:0] n_res;
  assign n_res = {1'b0, pre_v} + {1'b0, idle_v};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      pend_q <= OpAssign;
      kw_q   <= KwNone;
      line_q <= LineBits'(1);
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      if (in_acc) begin
        mode_q <= mode_d;
        pend_q <= pend_d;
        kw_q   <= kw_d;
        line_q <= line_d;
        wptr_q <= wptr_q + n_res;
      end
      if (out_acc) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + (in_acc ? {1'b0, n_res} : 3'd0) - {2'b00, out_acc};
    end
  end

  // queue storage: first result at the write pointer, a second one after it
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (pre_v) fifo_q[wptr_q] <= pre;
      else if (idle_v) fifo_q[wptr_q] <= idle;
      if (pre_v && idle_v) fifo_q[wptr_q + 2'd1] <= idle;
    end
  end

  assign m_axis_tdata_o = {fifo_q[rptr_q].line[15:0], fifo_q[rptr_q].text};
  assign m_axis_tuser_o = {fifo_q[rptr_q].has, fifo_q[rptr_q].kind};
  assign m_axis_tlast_o = fifo_q[rptr_q].last;

endmodule

[tb/source_text_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// Self-checking bench for the byte-stream tokenizer. A queue of source beats
// (directed text and random token sequences with noise and end markers)
// feeds a bursty driver. Each accepted beat runs a scanner model that queues
// the expected tokens. The monitor checks every output beat field by field
// while the receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;
  import stt_pkg::*;

  localparam int unsigned RunLimit = 3_000_000;
  localparam int unsigned RandBeats = 400;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;

  typedef struct packed {
    logic       req;
    logic [7:0] ch;
  } src_beat_t;

  typedef enum logic [1:0] {
    PatOpen,
    PatCoin,
    PatMostly,
    PatSparse
  } ready_pat_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic [5:0]  m_user;
  logic        m_last;

  source_text_tokenizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),   // [7:0] source_byte
    .s_axis_tuser_i (s_user),   // [0] req_type
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),   // [7:0] text_byte, [23:8] line_number
    .m_axis_tuser_o (m_user),   // [4:0] token_kind, [5] has_byte
    .m_axis_tlast_o (m_last)    // token_end
  );

  always #1 clk_i = ~clk_i;

  src_beat_t pending_beats[$];
  result_t   expected_tokens[$];
  int unsigned err_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned total_beats = 0;
  int unsigned sent_cnt = 0;

  // --------------------------------------------------------------------------
  // Scanner model
  // --------------------------------------------------------------------------
  mode_e               scan_st = ModeIdle;
  op_e                 op_pend = OpAssign;
  kw_e                 kw_st = KwNone;
  logic [LineBits-1:0] line_cnt = LineBits'(1);

  function automatic bit digit_ch(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic bit word_start(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic kw_e advance_keyword(kw_e t, logic [7:0] c);
    if (t == KwP && c == "r") return KwPr;
    if (t == KwPr && c == "i") return KwPri;
    if (t == KwPri && c == "n") return KwPrin;
    if (t == KwPrin && c == "t") return KwPrint;
    if (t == KwI && c == "f") return KwIf;
    return KwNone;
  endfunction

  task automatic note_token(kind_t k, logic [7:0] b, logic has, logic last);
    result_t r;
    r.kind = k;
    r.text = has ? b : 8'h00;
    r.has  = has;
    r.last = last;
    r.line = line_cnt;
    expected_tokens = {expected_tokens, r};
  endtask

  task automatic clear_scanner();
    scan_st  = ModeIdle;
    op_pend  = OpAssign;
    kw_st    = KwNone;
    line_cnt = LineBits'(1);
  endtask

  task automatic close_word();
    if (kw_st == KwPrint) note_token(KPrint, 8'h00, 1'b0, 1'b1);
    else if (kw_st == KwIf) note_token(KIf, 8'h00, 1'b0, 1'b1);
    else note_token(KIdent, 8'h00, 1'b0, 1'b1);
    kw_st   = KwNone;
    scan_st = ModeIdle;
  endtask

  task automatic close_pending();
    case (op_pend)
      OpAssign: note_token(KAssign, 8'h00, 1'b0, 1'b1);
      OpGt:     note_token(KGt, 8'h00, 1'b0, 1'b1);
      OpLt:     note_token(KLt, 8'h00, 1'b0, 1'b1);
      default:  note_token(KUnknown, "!", 1'b1, 1'b1);
    endcase
    scan_st = ModeIdle;
    op_pend = OpAssign;
  endtask

  task automatic scan_fresh(logic [7:0] c);
    scan_st = ModeIdle;
    if (c == " " || c == ChTab || c == ChCr) begin
    end else if (c == ChLf) begin
      note_token(KNewline, 8'h00, 1'b0, 1'b1);
      if (line_cnt != '1) line_cnt = line_cnt + LineBits'(1);
    end else if (c == "#") begin
      scan_st = ModeComment;
    end else if (digit_ch(c)) begin
      scan_st = ModeInt;
      note_token(KNumber, c, 1'b1, 1'b0);
    end else if (c == "\"") begin
      scan_st = ModeStr;
    end else if (word_start(c)) begin
      scan_st = ModeIdent;
      kw_st = (c == "p") ? KwP : (c == "i") ? KwI : KwNone;
      note_token(KIdent, c, 1'b1, 1'b0);
    end else begin
      case (c)
        "+": note_token(KPlus, 8'h00, 1'b0, 1'b1);
        "-": note_token(KMinus, 8'h00, 1'b0, 1'b1);
        "*": note_token(KStar, 8'h00, 1'b0, 1'b1);
        "/": note_token(KSlash, 8'h00, 1'b0, 1'b1);
        "(": note_token(KLParen, 8'h00, 1'b0, 1'b1);
        ")": note_token(KRParen, 8'h00, 1'b0, 1'b1);
        "{": note_token(KLBrace, 8'h00, 1'b0, 1'b1);
        "}": note_token(KRBrace, 8'h00, 1'b0, 1'b1);
        "=": begin op_pend = OpAssign; scan_st = ModeOp; end
        ">": begin op_pend = OpGt; scan_st = ModeOp; end
        "<": begin op_pend = OpLt; scan_st = ModeOp; end
        "!": begin op_pend = OpBang; scan_st = ModeOp; end
        default: note_token(KUnknown, c, 1'b1, 1'b1);
      endcase
    end
  endtask

  task automatic predict_beat(logic req, logic [7:0] c);
    if (req) begin
      case (scan_st)
        ModeInt, ModeFrac: note_token(KNumber, 8'h00, 1'b0, 1'b1);
        ModeStr, ModeEsc:  note_token(KString, 8'h00, 1'b0, 1'b1);
        ModeIdent:         close_word();
        ModeOp:            close_pending();
        default: ;
      endcase
      note_token(KEof, 8'h00, 1'b0, 1'b1);
      clear_scanner();
    end else begin
      case (scan_st)
        ModeInt, ModeFrac: begin
          if (digit_ch(c)) begin
            note_token(KNumber, c, 1'b1, 1'b0);
          end else if (c == "." && scan_st == ModeInt) begin
            scan_st = ModeFrac;
            note_token(KNumber, c, 1'b1, 1'b0);
          end else begin
            note_token(KNumber, 8'h00, 1'b0, 1'b1);
            scan_fresh(c);
          end
        end
        ModeStr: begin
          if (c == "\"") begin
            note_token(KString, 8'h00, 1'b0, 1'b1);
            scan_st = ModeIdle;
          end else if (c == "\\") begin
            scan_st = ModeEsc;
          end else begin
            note_token(KString, c, 1'b1, 1'b0);
          end
        end
        ModeEsc: begin
          note_token(KString, (c == "n") ? ChLf : (c == "t") ? ChTab : c, 1'b1, 1'b0);
          scan_st = ModeStr;
        end
        ModeIdent: begin
          if (word_start(c) || digit_ch(c)) begin
            kw_st = advance_keyword(kw_st, c);
            note_token(KIdent, c, 1'b1, 1'b0);
          end else begin
            close_word();
            scan_fresh(c);
          end
        end
        ModeComment: if (c == ChLf) scan_fresh(c);
        ModeOp: begin
          if (c == "=") begin
            case (op_pend)
              OpAssign: note_token(KEq, 8'h00, 1'b0, 1'b1);
              OpGt:     note_token(KGe, 8'h00, 1'b0, 1'b1);
              OpLt:     note_token(KLe, 8'h00, 1'b0, 1'b1);
              default:  note_token(KNe, 8'h00, 1'b0, 1'b1);
            endcase
            scan_st = ModeIdle;
            op_pend = OpAssign;
          end else begin
            close_pending();
            scan_fresh(c);
          end
        end
        default: scan_fresh(c);
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Source text builders
  // --------------------------------------------------------------------------
  task automatic add_byte(logic [7:0] b);
    src_beat_t t;
    t.req = 1'b0;
    t.ch  = b;
    pending_beats = {pending_beats, t};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_end();
    src_beat_t t;
    t.req = 1'b1;
    t.ch  = 8'($urandom_range(0, 255));
    pending_beats = {pending_beats, t};
  endtask

  task automatic add_random_token();
    string alnum;
    string near_kw[9];
    string ops;
    int    n;
    logic [7:0] ch;
    alnum   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    ops     = "+-*/(){}";
    near_kw = '{"print", "if", "pri", "iff", "printf", "i", "p", "pRint", "if_"};
    case ($urandom_range(0, 15))
      0, 1: begin
        n = $urandom_range(1, 4);
        repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          add_byte(".");
          repeat ($urandom_range(0, 3)) add_byte(8'("0" + $urandom_range(0, 9)));
          if ($urandom_range(0, 3) == 0) add_byte(".");
        end
      end
      2: add_text(near_kw[$urandom_range(0, 8)]);
      3: begin
        add_byte(alnum[$urandom_range(0, 52)]);
        repeat ($urandom_range(0, 5)) add_byte(alnum[$urandom_range(0, 62)]);
      end
      4: begin
        add_byte("\"");
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0, 1, 2: begin
              ch = 8'($urandom_range(32, 126));
              add_byte((ch == "\"" || ch == "\\") ? 8'("a") : ch);
            end
            3: begin
              add_byte("\\");
              case ($urandom_range(0, 4))
                0: add_byte("n");
                1: add_byte("t");
                2: add_byte("\"");
                3: add_byte("\\");
                default: add_byte(8'($urandom_range(0, 255)));
              endcase
            end
            4: add_byte(ChLf);
            default: add_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'h00);
          endcase
        end
        if ($urandom_range(0, 6) != 0) add_byte("\"");
      end
      5, 6: add_byte(ops[$urandom_range(0, 7)]);
      7, 8: begin
        case ($urandom_range(0, 3))
          0: add_byte("=");
          1: add_byte(">");
          2: add_byte("<");
          default: add_byte("!");
        endcase
        if ($urandom_range(0, 1)) add_byte("=");
      end
      9, 10: begin
        case ($urandom_range(0, 2))
          0: add_byte(" ");
          1: add_byte(ChTab);
          default: add_byte(ChCr);
        endcase
      end
      11: add_byte(ChLf);
      12: begin
        add_byte("#");
        repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
        add_byte(ChLf);
      end
      13: add_byte(8'($urandom_range(0, 255)));
      14: add_end();
      default: add_byte(8'($urandom_range(32, 126)));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  src_beat_t   next_beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= 8'h00;
      s_user  <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        predict_beat(s_user, s_data);
        sent_cnt++;
      end
      // hold an offered beat until it is taken
      if (!s_valid || s_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          next_beat = pending_beats.pop_front();
          s_valid <= 1'b1;
          s_data  <= next_beat.ch;
          s_user  <= next_beat.req;
          burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
              burst_left = $urandom_range(100, 300);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(0, 6);
            end
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern
  // --------------------------------------------------------------------------
  ready_pat_e  ready_pat = PatOpen;
  int unsigned pat_left = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        ready_pat = ready_pat_e'($urandom_range(0, 3));
        pat_left  = $urandom_range(16, 160);
      end else begin
        pat_left--;
      end
      // one long hold-off so the result queue fills and input backs up
      if (!holdoff_done && checked_cnt >= 150) begin
        holdoff_left = 500;
        holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_ready <= 1'b0;
      end else begin
        case (ready_pat)
          PatOpen:   m_ready <= 1'b1;
          PatCoin:   m_ready <= 1'($urandom_range(0, 1));
          PatMostly: m_ready <= ($urandom_range(0, 7) != 0);
          default:   m_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  result_t want_tok;

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (expected_tokens.size() == 0) begin
        err_cnt++;
        $error("token beat with nothing expected: kind %0d", m_user[4:0]);
      end else begin
        want_tok = expected_tokens.pop_front();
        check_field("token_kind", 32'(want_tok.kind), 32'(m_user[4:0]));
        check_field("text_byte", 32'(want_tok.text), 32'(m_data[7:0]));
        check_field("has_byte", 32'(want_tok.has), 32'(m_user[5]));
        check_field("token_end", 32'(want_tok.last), 32'(m_last));
        check_field("line_number", 32'(want_tok.line), 32'(m_data[23:8]));
      end
      checked_cnt <= checked_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RunLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // keywords, number with a second point, string escapes, raw newline and
    // high byte in a string, NUL and high bytes, comment, operator pairs
    add_text("print(if 7.5.");
    add_byte("\"");
    add_text("a\\n\\q");
    add_byte(ChLf);
    add_byte(8'h80);
    add_byte("\"");
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte("#");
    add_byte(8'hff);
    add_byte(ChLf);
    add_text("!x>=<=!==");
    add_end();
    // unterminated string ending in a lone backslash
    add_text("\"b\\");
    add_end();
    add_end();

    while (pending_beats.size() < RandBeats) add_random_token();
    add_end();
    total_beats = pending_beats.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt < total_beats || expected_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (err_cnt == 0 && expected_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
